// ----- sv/sbit_pkg.sv -----
// sbit_pkg: shared types and constants of the sparse block image translator
// used by the divider, the sequencer and the top level; no dependencies
package sbit_pkg;

  localparam int unsigned OFF_W = 41;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned BLK_W = 27;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned RANK_W = 15;
  localparam logic [OFF_W-1:0] FULL_DISC_BYTES = 41'd1459978240;
  localparam logic [BLK_W-1:0] MAX_BLOCK_BYTES = 27'd67108864;

  typedef enum logic [1:0] {
    CFG_SPARSE_MODE = 2'd0,
    CFG_BLOCK_BYTES = 2'd1,
    CFG_RAW_BYTES   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             kind;
    logic             map_restart;
    logic             block_stored;
    logic [OFF_W-1:0] read_offset;
    logic [LEN_W-1:0] read_length;
  } in_item_t;

  typedef struct packed {
    logic             zero_fill;
    logic [OFF_W-1:0] source_offset;
    logic [OFF_W-1:0] logical_offset;
    logic [LEN_W-1:0] chunk_bytes;
    logic             last_chunk;
    logic             out_of_range;
    logic             truncated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CHECK,
    ST_DIV,
    ST_DIV_WAIT,
    ST_LOOKUP,
    ST_LOOKUP_WAIT,
    ST_SRC,
    ST_EMIT
  } state_t;

endpackage

// ----- sv/sbit_div.sv -----
// sbit_div: restoring divider, one quotient bit per cycle
// divides a 41-bit offset by a 27-bit block size; uses sbit_pkg
module sbit_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sbit_pkg::OFF_W-1:0]    dividend,
  input  logic [sbit_pkg::BLK_W-1:0]    divisor,
  output logic                          done,
  output logic [sbit_pkg::OFF_W-1:0]    quotient,
  output logic [sbit_pkg::BLK_W-1:0]    remainder
);

  localparam int unsigned CNT_W = $clog2(sbit_pkg::OFF_W + 1);

  logic [sbit_pkg::OFF_W-1:0] quo_r, quo_nxt;
  logic [sbit_pkg::BLK_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;
  logic [sbit_pkg::BLK_W:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(sbit_pkg::OFF_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[sbit_pkg::BLK_W-1:0], quo_r[sbit_pkg::OFF_W-1]};
      quo_nxt = {quo_r[sbit_pkg::OFF_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt    = trial - {1'b0, divisor};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[sbit_pkg::BLK_W-1:0];

endmodule

// ----- sv/sparse_block_image_translator_unit.sv -----
// sparse_block_image_translator_unit: top level, sequencer, block table and map state
// uses sbit_pkg and sbit_div
//
//  channel | ports                          | handshake
//  in      | in_start, in_busy, in_item     | accepted when in_start & !in_busy
//  out     | out_valid, out_item            | one-cycle strobe, cannot be held off
//  cfg     | cfg_valid, cfg_ready, cfg_*    | written when cfg_valid & cfg_ready
//
// a map item never raises busy; a read request holds busy
// through the size and range check, then in sparse mode runs for each chunk
// the divider start, the divider steps until done, the table read, the
// rank multiply, the source add and the emit, for at most MAX_CHUNKS chunks.
// reset is synchronous; the block table is not cleared, only entries up to
// the last stored block are ever used. each result strobes in the cycle after
// the cycle that emits it, the last one in the first cycle with busy low.
module sparse_block_image_translator_unit #(
  parameter int unsigned MAP_ENTRIES  = 32760,
  parameter int unsigned HEADER_BYTES = 32768,
  parameter int unsigned MAX_CHUNKS   = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_start,
  output logic                        in_busy,
  input  sbit_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output sbit_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [sbit_pkg::OFF_W-1:0]  cfg_data
);

  localparam int unsigned OW = sbit_pkg::OFF_W;
  localparam int unsigned LW = sbit_pkg::LEN_W;
  localparam int unsigned BW = sbit_pkg::BLK_W;
  localparam int unsigned AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [sbit_pkg::IDX_W-1:0] MAP_FULL = sbit_pkg::IDX_W'(MAP_ENTRIES);

  logic                 sparse_r;
  logic [BW-1:0]        bb_cfg_r;
  logic [OW-1:0]        raw_r;

  logic [sbit_pkg::IDX_W-1:0] loaded_r, stored_r, last_r;
  logic [sbit_pkg::IDX_W-1:0] table_mem [MAP_ENTRIES];
  logic [sbit_pkg::IDX_W-1:0] tab_rd_r;

  sbit_pkg::state_t     state_r, state_nxt;
  sbit_pkg::in_item_t   item_r;
  logic [BW-1:0]        bb_r;
  logic [OW-1:0]        size_r, size_nxt;
  logic [OW-1:0]        pos_r, pos_nxt;
  logic [LW-1:0]        left_r, left_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [OW-1:0]        blk_r, blk_nxt;
  logic [BW-1:0]        within_r, within_nxt;
  logic [OW-1:0]        src_r, src_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sbit_pkg::out_item_t  out_r, out_nxt;

  logic                 div_start, div_done;
  logic [OW-1:0]        div_q;
  logic [BW-1:0]        div_rem;
  logic [BW-1:0]        eff_bb;
  logic [OW-1:0]        avail;
  logic [LW-1:0]        clip_len, n_chunk;
  logic [BW:0]          to_border;
  logic                 stored_hit;
  logic                 accept;

  assign accept    = in_start && (state_r == sbit_pkg::ST_IDLE);
  assign in_busy   = (state_r != sbit_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (bb_cfg_r == '0) eff_bb = BW'(1);
    else if (bb_cfg_r > sbit_pkg::MAX_BLOCK_BYTES) eff_bb = sbit_pkg::MAX_BLOCK_BYTES;
    else eff_bb = bb_cfg_r;
  end

  // configuration and map state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sparse_r <= 1'b0;
      bb_cfg_r <= BW'(2097152);
      raw_r    <= '0;
      loaded_r <= '0;
      stored_r <= '0;
      last_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          sbit_pkg::CFG_SPARSE_MODE: sparse_r <= cfg_data[0];
          sbit_pkg::CFG_BLOCK_BYTES: bb_cfg_r <= cfg_data[BW-1:0];
          sbit_pkg::CFG_RAW_BYTES:   raw_r    <= cfg_data;
          default: ;
        endcase
      end
      if (accept && !in_item.kind) begin
        if (in_item.map_restart) begin
          if (in_item.block_stored) begin
            stored_r <= sbit_pkg::IDX_W'(1);
            last_r   <= sbit_pkg::IDX_W'(1);
          end else begin
            stored_r <= '0;
            last_r   <= '0;
          end
          loaded_r <= sbit_pkg::IDX_W'(1);
        end else if (loaded_r < MAP_FULL) begin
          if (in_item.block_stored) begin
            stored_r <= stored_r + 1'b1;
            last_r   <= loaded_r + 1'b1;
          end
          loaded_r <= loaded_r + 1'b1;
        end
      end
    end
  end

  // block table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && !in_item.kind) begin
      if (in_item.map_restart) begin
        table_mem[0] <= in_item.block_stored ? 16'h8000 : 16'h0000;
      end else if (loaded_r < MAP_FULL) begin
        table_mem[loaded_r[AW-1:0]] <= in_item.block_stored ?
          {1'b1, stored_r[sbit_pkg::RANK_W-1:0]} : 16'h0000;
      end
    end
    if (state_r == sbit_pkg::ST_LOOKUP) begin
      tab_rd_r <= table_mem[blk_r[AW-1:0]];
    end
  end

  sbit_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (pos_r),
    .divisor   (bb_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign avail      = size_r - item_r.read_offset;
  assign clip_len   = (avail < OW'(item_r.read_length)) ? avail[LW-1:0] : item_r.read_length;
  assign to_border  = {1'b0, bb_r} - {1'b0, within_r};
  assign n_chunk    = ({{(LW-BW-1){1'b0}}, to_border} < left_r) ?
                      LW'(to_border) : left_r;
  assign stored_hit = (blk_r < OW'(last_r)) && (blk_r < OW'(MAP_ENTRIES)) && tab_rd_r[15];

  always_comb begin
    logic [OW+BW-1:0] prod;
    state_nxt     = state_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    k_nxt         = k_r;
    blk_nxt       = blk_r;
    within_nxt    = within_r;
    src_nxt       = src_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_start     = 1'b0;
    prod          = '0;
    unique case (state_r)
      sbit_pkg::ST_IDLE: begin
        if (accept && in_item.kind) state_nxt = sbit_pkg::ST_SIZE;
      end
      sbit_pkg::ST_SIZE: begin
        // 16 x 27 multiply for the image size
        if (!sparse_r) begin
          size_nxt = raw_r;
        end else begin
          prod = (OW+BW)'(last_r) * (OW+BW)'(bb_r);
          size_nxt = prod[OW-1:0];
          if (size_nxt < sbit_pkg::FULL_DISC_BYTES &&
              (OW+BW)'(MAP_ENTRIES) * (OW+BW)'(bb_r) >=
              (OW+BW)'(sbit_pkg::FULL_DISC_BYTES)) begin
            size_nxt = sbit_pkg::FULL_DISC_BYTES;
          end
        end
        state_nxt = sbit_pkg::ST_CHECK;
      end
      sbit_pkg::ST_CHECK: begin
        out_nxt = '0;
        out_nxt.logical_offset = item_r.read_offset;
        pos_nxt  = item_r.read_offset;
        left_nxt = clip_len;
        k_nxt    = '0;
        if (item_r.read_offset >= size_r) begin
          out_nxt.out_of_range = 1'b1;
          out_nxt.last_chunk   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = sbit_pkg::ST_IDLE;
        end else if (clip_len == '0) begin
          out_nxt.last_chunk = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = sbit_pkg::ST_IDLE;
        end else if (!sparse_r) begin
          out_nxt.source_offset = item_r.read_offset;
          out_nxt.chunk_bytes   = clip_len;
          out_nxt.last_chunk    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = sbit_pkg::ST_IDLE;
        end else begin
          state_nxt = sbit_pkg::ST_DIV;
        end
      end
      sbit_pkg::ST_DIV: begin
        div_start = 1'b1;
        state_nxt = sbit_pkg::ST_DIV_WAIT;
      end
      sbit_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          blk_nxt    = div_q;
          within_nxt = div_rem;
          state_nxt  = sbit_pkg::ST_LOOKUP;
        end
      end
      sbit_pkg::ST_LOOKUP: state_nxt = sbit_pkg::ST_LOOKUP_WAIT;
      sbit_pkg::ST_LOOKUP_WAIT: begin
        // rank times block size, 15 x 27
        prod = (OW+BW)'(tab_rd_r[sbit_pkg::RANK_W-1:0]) * (OW+BW)'(bb_r);
        src_nxt = prod[OW-1:0];
        state_nxt = sbit_pkg::ST_SRC;
      end
      sbit_pkg::ST_SRC: begin
        src_nxt = src_r + OW'(HEADER_BYTES) + OW'(within_r);
        state_nxt = sbit_pkg::ST_EMIT;
      end
      sbit_pkg::ST_EMIT: begin
        out_nxt = '0;
        out_nxt.logical_offset = pos_r;
        out_nxt.chunk_bytes    = n_chunk;
        if (stored_hit) out_nxt.source_offset = src_r;
        else out_nxt.zero_fill = 1'b1;
        out_valid_nxt = 1'b1;
        pos_nxt  = pos_r + OW'(n_chunk);
        left_nxt = left_r - n_chunk;
        k_nxt    = k_r + 1'b1;
        if (left_r == n_chunk) begin
          out_nxt.last_chunk = 1'b1;
          state_nxt = sbit_pkg::ST_IDLE;
        end else if (k_r == CW'(MAX_CHUNKS - 1)) begin
          out_nxt.last_chunk = 1'b1;
          out_nxt.truncated  = 1'b1;
          state_nxt = sbit_pkg::ST_IDLE;
        end else begin
          state_nxt = sbit_pkg::ST_DIV;
        end
      end
      default: state_nxt = sbit_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbit_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      item_r <= in_item;
      bb_r   <= eff_bb;
    end
    size_r   <= size_nxt;
    pos_r    <= pos_nxt;
    left_r   <= left_nxt;
    k_r      <= k_nxt;
    blk_r    <= blk_nxt;
    within_r <= within_nxt;
    src_r    <= src_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
